[src/les_pkg.sv]
// ----------------------------------------------------------------------------
// LOOK elevator scheduler package
// Shared types, event codes, heading codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package les_pkg;

  localparam int FLW = 8;

  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  from;
    logic [4:0]  to;
    logic [11:0] wt;
  } entry_t;

  localparam int EW = $bits(entry_t);

  localparam logic [2:0] EV_QUEUED   = 3'd0;
  localparam logic [2:0] EV_REJECTED = 3'd1;
  localparam logic [2:0] EV_ALIGHTED = 3'd2;
  localparam logic [2:0] EV_BOARDED  = 3'd3;
  localparam logic [2:0] EV_REFUSED  = 3'd4;
  localparam logic [2:0] EV_STATUS   = 3'd5;

  localparam logic [1:0] HEAD_IDLE = 2'd0;
  localparam logic [1:0] HEAD_UP   = 2'd1;
  localparam logic [1:0] HEAD_DOWN = 2'd2;

  localparam logic REG_WEIGHT_LIMIT = 1'b0;
  localparam logic REG_RIDER_LIMIT  = 1'b1;

  typedef struct packed {
    logic capture;
    logic step_init;
    logic idx_inc;
    logic p1_init;
    logic p2_init;
    logic unl_do;
    logic p1_do;
    logic p2_do;
    logic fin_do;
    logic add_do;
  } les_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic slot_valid;
    logic unl_hit;
    logic car_end;
    logic p1_end;
    logic p2_end;
  } les_sts_t;

endpackage

[src/les_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module les_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/les_ctrl.sv]
// ----------------------------------------------------------------------------
// LOOK elevator scheduler controller
// Sequences add, unload scan, queue compaction, boarding and the final move.
// ----------------------------------------------------------------------------
module les_ctrl import les_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_req_type_i,
  input  les_sts_t sts_i,
  output logic     in_stall_o,
  output les_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_UNL_RD = 4'd2;
  localparam logic [3:0] S_UNL_EV = 4'd3;
  localparam logic [3:0] S_P1_RD  = 4'd4;
  localparam logic [3:0] S_P1_EV  = 4'd5;
  localparam logic [3:0] S_P2_RD  = 4'd6;
  localparam logic [3:0] S_P2_EV  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_req_type_i) begin
            cmd_o.step_init = 1'b1;
            state_d = S_UNL_RD;
          end else begin
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        if (sts_i.can_emit) begin
          cmd_o.add_do = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_UNL_RD: begin
        if (sts_i.car_end) begin
          cmd_o.p1_init = 1'b1;
          state_d = S_P1_RD;
        end else if (!sts_i.slot_valid) begin
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = S_UNL_EV;
        end
      end
      S_UNL_EV: begin
        if (!sts_i.unl_hit || sts_i.can_emit) begin
          cmd_o.unl_do  = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d = S_UNL_RD;
        end
      end
      S_P1_RD: begin
        if (sts_i.p1_end) begin
          cmd_o.p2_init = 1'b1;
          state_d = S_P2_RD;
        end else begin
          state_d = S_P1_EV;
        end
      end
      S_P1_EV: begin
        cmd_o.p1_do   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = S_P1_RD;
      end
      S_P2_RD: begin
        if (sts_i.p2_end) begin
          state_d = S_FIN;
        end else begin
          state_d = S_P2_EV;
        end
      end
      S_P2_EV: begin
        if (sts_i.can_emit) begin
          cmd_o.p2_do   = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d = S_P2_RD;
        end
      end
      S_FIN: begin
        if (sts_i.can_emit) begin
          cmd_o.fin_do = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[src/les_dp.sv]
// ----------------------------------------------------------------------------
// LOOK elevator scheduler datapath
// Wait queue, pulled-passenger buffer, car table, car state and result register.
// ----------------------------------------------------------------------------
module les_dp import les_pkg::*; #(
  parameter int WAIT_DEPTH = 16,
  parameter int CAR_DEPTH  = 16,
  parameter int TOP_FLOOR  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] in_passenger_id_i,
  input  logic [4:0]  in_from_floor_i,
  input  logic [4:0]  in_to_floor_i,
  input  logic [11:0] in_body_weight_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  les_cmd_t    cmd_i,
  output les_sts_t    sts_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_event_kind_o,
  output logic [15:0] out_rider_id_o,
  output logic [4:0]  out_car_floor_o,
  output logic [1:0]  out_heading_o,
  output logic [15:0] out_load_weight_o,
  output logic [4:0]  out_rider_count_o,
  output logic [4:0]  out_waiting_count_o,
  output logic        out_overload_o,
  output logic        out_last_o
);

  localparam int WW   = $clog2(WAIT_DEPTH);
  localparam int CW   = $clog2(CAR_DEPTH);
  localparam int FW   = $clog2(WAIT_DEPTH + 1);
  localparam int CCW  = $clog2(CAR_DEPTH + 1);
  localparam int MAXD = (WAIT_DEPTH > CAR_DEPTH) ? WAIT_DEPTH : CAR_DEPTH;
  localparam int IW   = $clog2(MAXD + 1);
  localparam int SWR  = 12 + CCW;
  localparam int SW   = (SWR > 17) ? SWR : 17;
  localparam logic [FW-1:0]  WFULL = FW'(WAIT_DEPTH);
  localparam logic [IW-1:0]  CEND  = IW'(CAR_DEPTH);
  localparam logic [FLW-1:0] TOPF  = FLW'(TOP_FLOOR);
  localparam logic [FLW-1:0] BOTF  = FLW'(1);

  entry_t           cur_q, cur_d;
  logic [15:0]      wlim_q, wlim_d;
  logic [4:0]       rlim_q, rlim_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [FW-1:0]    wfill_q, wfill_d;
  logic [FW-1:0]    scan_q, scan_d;
  logic [FW-1:0]    pull_q, pull_d;
  logic [CAR_DEPTH-1:0] cvalid_q, cvalid_d;
  logic [CCW-1:0]   ccount_q, ccount_d;
  logic [SW-1:0]    sum_q, sum_d;
  logic [FLW-1:0]   floor_q, floor_d;
  logic [1:0]       head_q, head_d;
  logic             ovl_q, ovl_d;
  logic             above_q, above_d;
  logic             below_q, below_d;

  logic             ovalid_q, ovalid_d;
  logic [2:0]       okind_q, okind_d;
  logic [15:0]      oid_q, oid_d;
  logic [4:0]       ofloor_q, ofloor_d;
  logic [1:0]       ohead_q, ohead_d;
  logic [15:0]      oload_q, oload_d;
  logic [4:0]       ocount_q, ocount_d;
  logic [4:0]       owait_q, owait_d;
  logic             oovl_q, oovl_d;
  logic             olast_q, olast_d;

  logic          w_we, s_we, c_we;
  logic [WW-1:0] w_waddr;
  entry_t        w_wdata;
  logic [EW-1:0] w_rdata, s_rdata, c_rdata;
  entry_t        w_ent, s_ent, c_ent;
  logic [CW-1:0] free_slot;
  logic [15:0]   load_cur, load_d;
  logic [16:0]   new_wt;
  logic [31:0]   cap32;
  logic          can_emit, emit, ovl_upd;
  logic [2:0]    ev_kind;
  logic [15:0]   ev_id;
  logic          ev_last;

  assign w_ent = entry_t'(w_rdata);
  assign s_ent = entry_t'(s_rdata);
  assign c_ent = entry_t'(c_rdata);

  les_ram #(.WIDTH(EW), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (idx_q[WW-1:0]),
    .rdata_o (w_rdata)
  );

  les_ram #(.WIDTH(EW), .DEPTH(WAIT_DEPTH)) u_pull_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (pull_q[WW-1:0]),
    .wdata_i (w_rdata),
    .raddr_i (idx_q[WW-1:0]),
    .rdata_o (s_rdata)
  );

  les_ram #(.WIDTH(EW), .DEPTH(CAR_DEPTH)) u_car_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (free_slot),
    .wdata_i (s_rdata),
    .raddr_i (idx_q[CW-1:0]),
    .rdata_o (c_rdata)
  );

  always_comb begin
    free_slot = '0;
    for (int i = CAR_DEPTH - 1; i >= 0; i--) begin
      if (!cvalid_q[i]) begin
        free_slot = CW'(i);
      end
    end
  end

  assign load_cur = (sum_q > SW'(16'hFFFF)) ? 16'hFFFF : sum_q[15:0];
  assign new_wt   = {1'b0, load_cur} + 17'(s_ent.wt);
  assign cap32    = (32'(rlim_q) > 32'(CAR_DEPTH)) ? 32'(CAR_DEPTH) : 32'(rlim_q);
  assign can_emit = !ovalid_q || !out_stall_i;

  assign sts_o.can_emit   = can_emit;
  assign sts_o.slot_valid = cvalid_q[idx_q[CW-1:0]];
  assign sts_o.unl_hit    = (FLW'(c_ent.to) == floor_q);
  assign sts_o.car_end    = (idx_q == CEND);
  assign sts_o.p1_end     = (idx_q == IW'(scan_q));
  assign sts_o.p2_end     = (idx_q == IW'(pull_q));

  always_comb begin
    cur_d    = cur_q;
    wlim_d   = wlim_q;
    rlim_d   = rlim_q;
    idx_d    = idx_q;
    wfill_d  = wfill_q;
    scan_d   = scan_q;
    pull_d   = pull_q;
    cvalid_d = cvalid_q;
    ccount_d = ccount_q;
    sum_d    = sum_q;
    floor_d  = floor_q;
    head_d   = head_q;
    ovl_d    = ovl_q;
    above_d  = above_q;
    below_d  = below_q;
    w_we     = 1'b0;
    w_waddr  = wfill_q[WW-1:0];
    w_wdata  = cur_q;
    s_we     = 1'b0;
    c_we     = 1'b0;
    emit     = 1'b0;
    ovl_upd  = 1'b0;
    ev_kind  = EV_STATUS;
    ev_id    = '0;
    ev_last  = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WEIGHT_LIMIT: wlim_d = cfg_data_i;
        REG_RIDER_LIMIT:  rlim_d = cfg_data_i[4:0];
        default:          wlim_d = wlim_q;
      endcase
    end

    if (cmd_i.capture) begin
      cur_d = '{id: in_passenger_id_i, from: in_from_floor_i,
                to: in_to_floor_i, wt: in_body_weight_i};
    end
    if (cmd_i.step_init) begin
      idx_d   = '0;
      above_d = 1'b0;
      below_d = 1'b0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
    if (cmd_i.p1_init) begin
      idx_d   = '0;
      scan_d  = wfill_q;
      wfill_d = '0;
      pull_d  = '0;
    end
    if (cmd_i.p2_init) begin
      idx_d = '0;
    end

    if (cmd_i.unl_do) begin
      if (FLW'(c_ent.to) == floor_q) begin
        cvalid_d[idx_q[CW-1:0]] = 1'b0;
        sum_d    = sum_q - SW'(c_ent.wt);
        ccount_d = ccount_q - CCW'(1);
        ovl_upd  = 1'b1;
        emit     = 1'b1;
        ev_kind  = EV_ALIGHTED;
        ev_id    = c_ent.id;
      end else begin
        if (FLW'(c_ent.to) > floor_q) above_d = 1'b1;
        if (FLW'(c_ent.to) < floor_q) below_d = 1'b1;
      end
    end

    if (cmd_i.p1_do) begin
      if (FLW'(w_ent.from) == floor_q) begin
        s_we   = 1'b1;
        pull_d = pull_q + FW'(1);
      end else begin
        w_we    = 1'b1;
        w_wdata = w_ent;
        wfill_d = wfill_q + FW'(1);
        if (FLW'(w_ent.from) > floor_q) above_d = 1'b1;
        if (FLW'(w_ent.from) < floor_q) below_d = 1'b1;
      end
    end

    if (cmd_i.p2_do) begin
      emit  = 1'b1;
      ev_id = s_ent.id;
      if (new_wt <= {1'b0, wlim_q} && 32'(ccount_q) < cap32) begin
        c_we     = 1'b1;
        cvalid_d[free_slot] = 1'b1;
        sum_d    = sum_q + SW'(s_ent.wt);
        ccount_d = ccount_q + CCW'(1);
        ovl_upd  = 1'b1;
        ev_kind  = EV_BOARDED;
        if (FLW'(s_ent.to) > floor_q) above_d = 1'b1;
        if (FLW'(s_ent.to) < floor_q) below_d = 1'b1;
      end else begin
        ev_kind = EV_REFUSED;
        if (wfill_q < WFULL) begin
          w_we    = 1'b1;
          w_wdata = s_ent;
          wfill_d = wfill_q + FW'(1);
        end
      end
    end

    if (cmd_i.add_do) begin
      emit    = 1'b1;
      ev_id   = cur_q.id;
      ev_last = 1'b1;
      if (wfill_q < WFULL) begin
        w_we    = 1'b1;
        wfill_d = wfill_q + FW'(1);
        ev_kind = EV_QUEUED;
      end else begin
        ev_kind = EV_REJECTED;
      end
    end

    if (cmd_i.fin_do) begin
      emit    = 1'b1;
      ev_kind = EV_STATUS;
      ev_last = 1'b1;
      ovl_upd = 1'b1;
      case (head_q)
        HEAD_DOWN: head_d = below_q ? HEAD_DOWN : (above_q ? HEAD_UP : HEAD_IDLE);
        HEAD_UP:   head_d = above_q ? HEAD_UP : (below_q ? HEAD_DOWN : HEAD_IDLE);
        default:   head_d = above_q ? HEAD_UP : (below_q ? HEAD_DOWN : HEAD_IDLE);
      endcase
      if (head_d == HEAD_UP) begin
        floor_d = (floor_q >= TOPF) ? TOPF : floor_q + FLW'(1);
      end else if (head_d == HEAD_DOWN) begin
        floor_d = (floor_q <= BOTF) ? BOTF : floor_q - FLW'(1);
      end
    end

    load_d = (sum_d > SW'(16'hFFFF)) ? 16'hFFFF : sum_d[15:0];
    if (ovl_upd) begin
      ovl_d = (load_d > wlim_q);
    end

    ovalid_d = emit | (ovalid_q & out_stall_i);
    okind_d  = okind_q;
    oid_d    = oid_q;
    ofloor_d = ofloor_q;
    ohead_d  = ohead_q;
    oload_d  = oload_q;
    ocount_d = ocount_q;
    owait_d  = owait_q;
    oovl_d   = oovl_q;
    olast_d  = olast_q;
    if (emit) begin
      okind_d  = ev_kind;
      oid_d    = ev_id;
      ofloor_d = floor_d[4:0];
      ohead_d  = head_d;
      oload_d  = load_d;
      ocount_d = 5'(ccount_d);
      owait_d  = 5'(wfill_d);
      oovl_d   = ovl_d;
      olast_d  = ev_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlim_q   <= 16'd7000;
      rlim_q   <= 5'd10;
      idx_q    <= '0;
      wfill_q  <= '0;
      scan_q   <= '0;
      pull_q   <= '0;
      cvalid_q <= '0;
      ccount_q <= '0;
      sum_q    <= '0;
      floor_q  <= BOTF;
      head_q   <= HEAD_IDLE;
      ovl_q    <= 1'b0;
      above_q  <= 1'b0;
      below_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      wlim_q   <= wlim_d;
      rlim_q   <= rlim_d;
      idx_q    <= idx_d;
      wfill_q  <= wfill_d;
      scan_q   <= scan_d;
      pull_q   <= pull_d;
      cvalid_q <= cvalid_d;
      ccount_q <= ccount_d;
      sum_q    <= sum_d;
      floor_q  <= floor_d;
      head_q   <= head_d;
      ovl_q    <= ovl_d;
      above_q  <= above_d;
      below_q  <= below_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    okind_q  <= okind_d;
    oid_q    <= oid_d;
    ofloor_q <= ofloor_d;
    ohead_q  <= ohead_d;
    oload_q  <= oload_d;
    ocount_q <= ocount_d;
    owait_q  <= owait_d;
    oovl_q   <= oovl_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o         = ovalid_q;
  assign out_event_kind_o    = okind_q;
  assign out_rider_id_o      = oid_q;
  assign out_car_floor_o     = ofloor_q;
  assign out_heading_o       = ohead_q;
  assign out_load_weight_o   = oload_q;
  assign out_rider_count_o   = ocount_q;
  assign out_waiting_count_o = owait_q;
  assign out_overload_o      = oovl_q;
  assign out_last_o          = olast_q;

endmodule

[src/look_elevator_scheduler.sv]
// ----------------------------------------------------------------------------
// LOOK elevator scheduler
// Single-car LOOK controller with a FIFO wait queue and a car rider table.
// ----------------------------------------------------------------------------
// An add transaction returns one result. The length of a step transaction
// grows with the number of riders in the car, of waiting passengers and of
// those waiting on the current floor, and with any stalls on the result side;
// it is set by the one-entry-per-read scans of the car table, the wait
// queue and the pulled-passenger buffer, each a RAM with registered read.
// Results are held in an output register; one result is emitted at a time.
module look_elevator_scheduler import les_pkg::*; #(
  parameter int WAIT_DEPTH = 16,
  parameter int CAR_DEPTH  = 16,
  parameter int TOP_FLOOR  = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_req_type_i,
  input  logic [15:0] in_passenger_id_i,
  input  logic [4:0]  in_from_floor_i,
  input  logic [4:0]  in_to_floor_i,
  input  logic [11:0] in_body_weight_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_event_kind_o,
  output logic [15:0] out_rider_id_o,
  output logic [4:0]  out_car_floor_o,
  output logic [1:0]  out_heading_o,
  output logic [15:0] out_load_weight_o,
  output logic [4:0]  out_rider_count_o,
  output logic [4:0]  out_waiting_count_o,
  output logic        out_overload_o,
  output logic        out_last_o
);

  les_cmd_t cmd;
  les_sts_t sts;

  assign cfg_ready_o = 1'b1;

  les_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_req_type_i),
    .sts_i         (sts),
    .in_stall_o    (in_stall_o),
    .cmd_o         (cmd)
  );

  les_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .CAR_DEPTH  (CAR_DEPTH),
    .TOP_FLOOR  (TOP_FLOOR)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_passenger_id_i   (in_passenger_id_i),
    .in_from_floor_i     (in_from_floor_i),
    .in_to_floor_i       (in_to_floor_i),
    .in_body_weight_i    (in_body_weight_i),
    .cfg_we_i            (cfg_valid_i & cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_event_kind_o    (out_event_kind_o),
    .out_rider_id_o      (out_rider_id_o),
    .out_car_floor_o     (out_car_floor_o),
    .out_heading_o       (out_heading_o),
    .out_load_weight_o   (out_load_weight_o),
    .out_rider_count_o   (out_rider_count_o),
    .out_waiting_count_o (out_waiting_count_o),
    .out_overload_o      (out_overload_o),
    .out_last_o          (out_last_o)
  );

  // an accepted transaction always stalls the input in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (out_event_kind_o == EV_QUEUED ||
                                    out_event_kind_o == EV_REJECTED ||
                                    out_event_kind_o == EV_STATUS)))
    else $error("last flag does not match event kind");

  a_overload_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_overload_o) |-> (out_load_weight_o != 16'd0))
    else $error("overload with empty car");

endmodule
